>>> rtl/kmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types, codes and defaults of the 2-D k-means clustering core.
// ----------------------------------------------------------------------------
package kmc_pkg;

  localparam int unsigned MaxPointsDef   = 1024;
  localparam int unsigned MaxClustersDef = 16;
  localparam int unsigned CoordW         = 32;
  localparam int unsigned CfgAddrW       = 4;

  localparam logic [1:0] OP_WRITE_POINT = 2'd0;
  localparam logic [1:0] OP_WRITE_CENT  = 2'd1;
  localparam logic [1:0] OP_RUN         = 2'd2;
  localparam logic [1:0] OP_READ_LABEL  = 2'd3;

  localparam logic [1:0] REG_POINT_COUNT   = 2'd0;
  localparam logic [1:0] REG_CLUSTER_COUNT = 2'd1;
  localparam logic [1:0] REG_MAX_ITER      = 2'd2;

  localparam logic [10:0] POINT_COUNT_RST   = 11'd1024;
  localparam logic [4:0]  CLUSTER_COUNT_RST = 5'd16;
  localparam logic [15:0] MAX_ITER_RST      = 16'd100;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         slot_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         cluster_index;
    logic signed [31:0] centroid_x;
    logic signed [31:0] centroid_y;
    logic [15:0]        rounds_done;
    logic [3:0]         point_label;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [10:0] point_count;
    logic [4:0]  cluster_count;
    logic [15:0] max_iterations;
  } cfg_t;

  typedef struct packed {
    logic wr_point;
    logic wr_cent;
    logic rd_label;
    logic run_init;
    logic round_init;
    logic pt_read;
    logic dist_diff;
    logic dist_mul;
    logic dist_cmp;
    logic pt_commit;
    logic c_clear;
    logic c_inc;
    logic div_start;
    logic upd_write;
    logic out_run;
    logic out_label;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic i_last;
    logic c_last;
    logic cnt_zero;
    logic div_done;
    logic moved;
    logic iter_zero;
    logic iter_hit;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/kmc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_div
// Radix-2 restoring divider: signed sum by unsigned count, one quotient bit
// per cycle, quotient truncated toward zero to 32 bits.
// ----------------------------------------------------------------------------
module kmc_div import kmc_pkg::*; #(
  parameter int unsigned SumW = 43,
  parameter int unsigned CntW = 11
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [SumW-1:0] dividend_i,
  input  logic [CntW-1:0]        divisor_i,
  output logic                   done_o,
  output logic signed [31:0]     quot_o
);

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic             busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  logic             neg_q, neg_d;
  logic [SumW-1:0]  num_q, num_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  dvs_q, dvs_d;
  logic [CntW:0]    trial;
  logic [CntW:0]    trial_sub;

  assign trial     = {rem_q, num_q[SumW-1]};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    neg_d  = neg_q;
    num_d  = num_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(SumW);
      neg_d  = dividend_i[SumW-1];
      num_d  = dividend_i[SumW-1] ? SumW'(-dividend_i) : SumW'(dividend_i);
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q - StepW'(1);
        if (trial >= {1'b0, dvs_q}) begin
          rem_d = trial_sub[CntW-1:0];
          num_d = {num_q[SumW-2:0], 1'b1};
        end else begin
          rem_d = trial[CntW-1:0];
          num_d = {num_q[SumW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = busy_q && (step_q == '0);
  assign quot_o = neg_q ? -$signed(num_q[31:0]) : $signed(num_q[31:0]);

endmodule

>>> rtl/kmc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_datapath
// Point, label and centroid storage, distance unit, per-cluster sums,
// mean dividers and the result register.
// ----------------------------------------------------------------------------
module kmc_datapath import kmc_pkg::*; #(
  parameter int unsigned MAX_POINTS   = MaxPointsDef,
  parameter int unsigned MAX_CLUSTERS = MaxClustersDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  input  in_word_t  in_word_i,
  input  cfg_t      cfg_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_word_t out_word_o
);

  localparam int unsigned PW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam int unsigned LW   = $clog2(MAX_CLUSTERS);
  localparam int unsigned KW   = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned SumW = CoordW + CntW;

  logic [63:0]           pmem [MAX_POINTS];
  logic [LW-1:0]         lmem [MAX_POINTS];
  logic signed [31:0]    cent_x [MAX_CLUSTERS];
  logic signed [31:0]    cent_y [MAX_CLUSTERS];
  logic signed [SumW-1:0] acc_x [MAX_CLUSTERS];
  logic signed [SumW-1:0] acc_y [MAX_CLUSTERS];
  logic [CntW-1:0]       acc_n [MAX_CLUSTERS];

  logic [CntW-1:0] n_used;
  logic [KW-1:0]   k_used;
  logic [PW-1:0]   i_q;
  logic [LW-1:0]   c_q;
  logic [LW-1:0]   best_q;
  logic [LW-1:0]   acc_sel;
  logic [64:0]     best_d_q;
  logic [64:0]     dist_sum;
  logic [63:0]     pt_q;
  logic signed [31:0] pt_x, pt_y, cur_cx, cur_cy;
  logic signed [32:0] ddx, ddy;
  logic [31:0]     adx_q, ady_q;
  logic [63:0]     sqx_q, sqy_q;
  logic [15:0]     rounds_q;
  logic            moved_q;
  logic [LW-1:0]   lbl_rd_q;
  logic            lbl_ok_q;
  logic            slot_pt_ok, slot_ct_ok;
  logic            qx_done, qy_done;
  logic signed [31:0] qx, qy;
  logic            out_valid_q;
  out_word_t       out_q, out_d;

  always_comb begin
    if (int'(cfg_i.point_count) > MAX_POINTS) begin
      n_used = CntW'(MAX_POINTS);
    end else begin
      n_used = CntW'(cfg_i.point_count);
    end
    if (cfg_i.cluster_count == '0) begin
      k_used = KW'(1);
    end else if (int'(cfg_i.cluster_count) > MAX_CLUSTERS) begin
      k_used = KW'(MAX_CLUSTERS);
    end else begin
      k_used = KW'(cfg_i.cluster_count);
    end
  end

  assign slot_pt_ok = int'(in_word_i.slot_index) < MAX_POINTS;
  assign slot_ct_ok = int'(in_word_i.slot_index) < MAX_CLUSTERS;

  // Point and label memories: one write, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_point && slot_pt_ok) begin
      pmem[PW'(in_word_i.slot_index)] <= {in_word_i.coord_x, in_word_i.coord_y};
    end
    if (cmd_i.pt_read) begin
      pt_q <= pmem[i_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_commit) begin
      lmem[i_q] <= best_q;
    end
    if (cmd_i.rd_label) begin
      lbl_rd_q <= lmem[PW'(in_word_i.slot_index)];
      lbl_ok_q <= slot_pt_ok;
    end
  end

  assign pt_x   = $signed(pt_q[63:32]);
  assign pt_y   = $signed(pt_q[31:0]);
  assign cur_cx = cent_x[c_q];
  assign cur_cy = cent_y[c_q];

  // Distance: abs difference, square, sum and compare in three steps.
  assign ddx      = 33'(pt_x) - 33'(cur_cx);
  assign ddy      = 33'(pt_y) - 33'(cur_cy);
  assign dist_sum = 65'(sqx_q) + 65'(sqy_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.dist_diff) begin
      adx_q <= ddx[32] ? 32'(-ddx) : ddx[31:0];
      ady_q <= ddy[32] ? 32'(-ddy) : ddy[31:0];
    end
    if (cmd_i.dist_mul) begin
      sqx_q <= 64'(adx_q) * 64'(adx_q);
      sqy_q <= 64'(ady_q) * 64'(ady_q);
    end
    if (cmd_i.dist_cmp && (c_q == '0 || dist_sum < best_d_q)) begin
      best_d_q <= dist_sum;
      best_q   <= c_q;
    end
  end

  // Centroid registers: loaded by the write opcode, updated with the mean.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_cent && slot_ct_ok) begin
      cent_x[LW'(in_word_i.slot_index)] <= in_word_i.coord_x;
      cent_y[LW'(in_word_i.slot_index)] <= in_word_i.coord_y;
    end else if (cmd_i.upd_write) begin
      cent_x[c_q] <= qx;
      cent_y[c_q] <= qy;
    end
  end

  assign acc_sel = cmd_i.pt_commit ? best_q : c_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.round_init) begin
      for (int j = 0; j < MAX_CLUSTERS; j++) begin
        acc_x[j] <= '0;
        acc_y[j] <= '0;
        acc_n[j] <= '0;
      end
    end else if (cmd_i.pt_commit) begin
      acc_x[acc_sel] <= acc_x[acc_sel] + SumW'(pt_x);
      acc_y[acc_sel] <= acc_y[acc_sel] + SumW'(pt_y);
      acc_n[acc_sel] <= acc_n[acc_sel] + CntW'(1);
    end
  end

  kmc_div #(.SumW(SumW), .CntW(CntW)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_x[acc_sel]),
    .divisor_i  (acc_n[acc_sel]),
    .done_o     (qx_done),
    .quot_o     (qx)
  );

  kmc_div #(.SumW(SumW), .CntW(CntW)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_y[acc_sel]),
    .divisor_i  (acc_n[acc_sel]),
    .done_o     (qy_done),
    .quot_o     (qy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q      <= '0;
      c_q      <= '0;
      rounds_q <= '0;
      moved_q  <= 1'b0;
    end else begin
      if (cmd_i.round_init) begin
        i_q <= '0;
      end else if (cmd_i.pt_commit) begin
        i_q <= i_q + PW'(1);
      end
      if (cmd_i.c_clear) begin
        c_q <= '0;
      end else if (cmd_i.c_inc) begin
        c_q <= c_q + LW'(1);
      end
      if (cmd_i.run_init) begin
        rounds_q <= '0;
      end else if (cmd_i.round_init) begin
        rounds_q <= rounds_q + 16'd1;
      end
      if (cmd_i.round_init) begin
        moved_q <= 1'b0;
      end else if (cmd_i.upd_write && (qx != cur_cx || qy != cur_cy)) begin
        moved_q <= 1'b1;
      end
    end
  end

  assign sts_o.n_zero    = (n_used == '0);
  assign sts_o.i_last    = (CntW'(i_q) + CntW'(1)) == n_used;
  assign sts_o.c_last    = (KW'(c_q) + KW'(1)) == k_used;
  assign sts_o.cnt_zero  = (acc_n[acc_sel] == '0);
  assign sts_o.div_done  = qx_done && qy_done;
  assign sts_o.moved     = moved_q;
  assign sts_o.iter_zero = (cfg_i.max_iterations == '0);
  assign sts_o.iter_hit  = (rounds_q == cfg_i.max_iterations);
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  // Result register
  always_comb begin
    out_d = '0;
    if (cmd_i.out_run) begin
      out_d.cluster_index = 4'(c_q);
      out_d.centroid_x    = cur_cx;
      out_d.centroid_y    = cur_cy;
      out_d.rounds_done   = rounds_q;
      out_d.last          = sts_o.c_last;
    end else begin
      out_d.point_label = lbl_ok_q ? 4'(lbl_rd_q) : 4'd0;
      out_d.last        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_run || cmd_i.out_label) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_run || cmd_i.out_label) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> rtl/kmc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_ctrl
// Sequencer for loads, label reads and the assign / update rounds of a run.
// ----------------------------------------------------------------------------
module kmc_ctrl import kmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] opcode_i,
  output logic       in_stall_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ROUND  = 4'd1;
  localparam logic [3:0] ST_PREAD  = 4'd2;
  localparam logic [3:0] ST_DIFF   = 4'd3;
  localparam logic [3:0] ST_MUL    = 4'd4;
  localparam logic [3:0] ST_CMP    = 4'd5;
  localparam logic [3:0] ST_COMMIT = 4'd6;
  localparam logic [3:0] ST_UINIT  = 4'd7;
  localparam logic [3:0] ST_UCHK   = 4'd8;
  localparam logic [3:0] ST_UDIV   = 4'd9;
  localparam logic [3:0] ST_UWR    = 4'd10;
  localparam logic [3:0] ST_REND   = 4'd11;
  localparam logic [3:0] ST_OINIT  = 4'd12;
  localparam logic [3:0] ST_OUT    = 4'd13;
  localparam logic [3:0] ST_LBL    = 4'd14;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_WRITE_POINT: cmd_o.wr_point = 1'b1;
            OP_WRITE_CENT:  cmd_o.wr_cent  = 1'b1;
            OP_READ_LABEL: begin
              cmd_o.rd_label = 1'b1;
              state_d        = ST_LBL;
            end
            OP_RUN: begin
              cmd_o.run_init = 1'b1;
              state_d        = sts_i.iter_zero ? ST_OINIT : ST_ROUND;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ROUND: begin
        cmd_o.round_init = 1'b1;
        state_d          = sts_i.n_zero ? ST_UINIT : ST_PREAD;
      end
      ST_PREAD: begin
        cmd_o.pt_read = 1'b1;
        cmd_o.c_clear = 1'b1;
        state_d       = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.dist_diff = 1'b1;
        state_d         = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.dist_mul = 1'b1;
        state_d        = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.dist_cmp = 1'b1;
        if (sts_i.c_last) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.c_inc = 1'b1;
          state_d     = ST_DIFF;
        end
      end
      ST_COMMIT: begin
        cmd_o.pt_commit = 1'b1;
        state_d         = sts_i.i_last ? ST_UINIT : ST_PREAD;
      end
      ST_UINIT: begin
        cmd_o.c_clear = 1'b1;
        state_d       = ST_UCHK;
      end
      ST_UCHK: begin
        // empty cluster keeps its centroid
        if (sts_i.cnt_zero) begin
          if (sts_i.c_last) begin
            state_d = ST_REND;
          end else begin
            cmd_o.c_inc = 1'b1;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_UDIV;
        end
      end
      ST_UDIV: begin
        if (sts_i.div_done) begin
          state_d = ST_UWR;
        end
      end
      ST_UWR: begin
        cmd_o.upd_write = 1'b1;
        if (sts_i.c_last) begin
          state_d = ST_REND;
        end else begin
          cmd_o.c_inc = 1'b1;
          state_d     = ST_UCHK;
        end
      end
      ST_REND: begin
        state_d = (!sts_i.moved || sts_i.iter_hit) ? ST_OINIT : ST_ROUND;
      end
      ST_OINIT: begin
        cmd_o.c_clear = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_run = 1'b1;
          if (sts_i.c_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.c_inc = 1'b1;
          end
        end
      end
      ST_LBL: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_label = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/kmeans_2d_clustering_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_2d_clustering_core
// Lloyd k-means on 2-D Q16.16 points with an APB register port.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | word
//  in      | input     | in_valid / in_stall | in_word_t (opcode, slot, x, y)
//  out     | output    | out_valid/out_stall | out_word_t (one per cluster/label)
//  cfg     | input     | APB psel / penable  | point_count, cluster_count, max_iter
//
// Point and centroid writes complete when accepted. A label read registers the
// label, then loads the result once the output is free. A run does up to max_iter
// assign / update rounds, stops once no centroid moves, then one word per cluster.
// Reset clears the controller and the configuration to 1024, 16 and 100.
// Stores are not cleared. A stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module kmeans_2d_clustering_core import kmc_pkg::*; #(
  parameter int unsigned MAX_POINTS   = MaxPointsDef,
  parameter int unsigned MAX_CLUSTERS = MaxClustersDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t       cfg_q;
  cmd_t       cmd;
  sts_t       sts;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.point_count    <= POINT_COUNT_RST;
      cfg_q.cluster_count  <= CLUSTER_COUNT_RST;
      cfg_q.max_iterations <= MAX_ITER_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_POINT_COUNT:   cfg_q.point_count    <= pwdata[10:0];
        REG_CLUSTER_COUNT: cfg_q.cluster_count  <= pwdata[4:0];
        REG_MAX_ITER:      cfg_q.max_iterations <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POINT_COUNT:   prdata = 32'(cfg_q.point_count);
      REG_CLUSTER_COUNT: prdata = 32'(cfg_q.cluster_count);
      REG_MAX_ITER:      prdata = 32'(cfg_q.max_iterations);
      default:           prdata = '0;
    endcase
  end

  kmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_word_i.opcode),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kmc_datapath #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_word_i),
    .cfg_i       (cfg_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

>>> dv/kmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_checker
// Watches the input, output and register channels of the k-means core,
// predicts each result word from its own copy of the stores and registers,
// and compares every accepted output word field by field in order.
// ----------------------------------------------------------------------------
module kmc_checker import kmc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_word_t            in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_word_t           out_word_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [CfgAddrW-1:0] paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic                pready_i,
  output int                  pending_o,
  output int                  errors_o
);

  logic signed [31:0] pt_x [MaxPointsDef];
  logic signed [31:0] pt_y [MaxPointsDef];
  logic signed [31:0] ct_x [MaxClustersDef];
  logic signed [31:0] ct_y [MaxClustersDef];
  logic [3:0]         label_mem [MaxPointsDef];
  cfg_t               cfg;
  out_word_t          expected_words [$];
  int                 errors;

  assign pending_o = expected_words.size();
  assign errors_o  = errors;

  function automatic logic [65:0] dist_sq(logic signed [31:0] ax, logic signed [31:0] ay,
                                          logic signed [31:0] bx, logic signed [31:0] by);
    longint dx;
    longint dy;
    logic [65:0] ux;
    logic [65:0] uy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    ux = 66'(dx);
    uy = 66'(dy);
    return ux * ux + uy * uy;
  endfunction

  function automatic void label_points(int n, int k);
    logic [65:0] best_d;
    logic [65:0] d;
    int best;
    for (int i = 0; i < n; i++) begin
      best = 0;
      best_d = dist_sq(pt_x[i], pt_y[i], ct_x[0], ct_y[0]);
      for (int c = 1; c < k; c++) begin
        d = dist_sq(pt_x[i], pt_y[i], ct_x[c], ct_y[c]);
        if (d < best_d) begin
          best_d = d;
          best = c;
        end
      end
      label_mem[i] = 4'(best);
    end
  endfunction

  function automatic bit move_centroids(int n, int k);
    longint sx;
    longint sy;
    longint m;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    bit moved;
    moved = 0;
    for (int c = 0; c < k; c++) begin
      sx = 0;
      sy = 0;
      m = 0;
      for (int i = 0; i < n; i++) begin
        if (label_mem[i] == c) begin
          sx += pt_x[i];
          sy += pt_y[i];
          m++;
        end
      end
      if (m != 0) begin
        nx = 32'(sx / m);
        ny = 32'(sy / m);
        if (nx != ct_x[c] || ny != ct_y[c]) moved = 1;
        ct_x[c] = nx;
        ct_y[c] = ny;
      end
    end
    return moved;
  endfunction

  function automatic void predict_clustering();
    int n;
    int k;
    int rounds;
    out_word_t w;
    n = (cfg.point_count > MaxPointsDef) ? MaxPointsDef : int'(cfg.point_count);
    k = (cfg.cluster_count == 0) ? 1 :
        (cfg.cluster_count > MaxClustersDef) ? MaxClustersDef : int'(cfg.cluster_count);
    rounds = cfg.max_iterations;
    for (int it = 1; it <= int'(cfg.max_iterations); it++) begin
      label_points(n, k);
      if (!move_centroids(n, k)) begin
        rounds = it;
        break;
      end
    end
    for (int c = 0; c < k; c++) begin
      w = '0;
      w.cluster_index = 4'(c);
      w.centroid_x = ct_x[c];
      w.centroid_y = ct_y[c];
      w.rounds_done = 16'(rounds);
      w.last = (c == k - 1);
      expected_words.push_back(w);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t w;
    out_word_t e;
    if (!rst_ni) begin
      cfg.point_count <= POINT_COUNT_RST;
      cfg.cluster_count <= CLUSTER_COUNT_RST;
      cfg.max_iterations <= MAX_ITER_RST;
      errors <= 0;
      expected_words.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_POINT_COUNT:   cfg.point_count <= pwdata_i[10:0];
          REG_CLUSTER_COUNT: cfg.cluster_count <= pwdata_i[4:0];
          REG_MAX_ITER:      cfg.max_iterations <= pwdata_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_word_i.opcode)
          OP_WRITE_POINT: begin
            pt_x[in_word_i.slot_index] = in_word_i.coord_x;
            pt_y[in_word_i.slot_index] = in_word_i.coord_y;
          end
          OP_WRITE_CENT: begin
            if (in_word_i.slot_index < MaxClustersDef) begin
              ct_x[in_word_i.slot_index] = in_word_i.coord_x;
              ct_y[in_word_i.slot_index] = in_word_i.coord_y;
            end
          end
          OP_RUN: predict_clustering();
          default: begin
            w = '0;
            w.point_label = label_mem[in_word_i.slot_index];
            w.last = 1'b1;
            expected_words.push_back(w);
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        w = out_word_i;
        if (expected_words.size() == 0) begin
          if (errors < 10) $display("%0t: unexpected output word %p", $realtime, w);
          errors <= errors + 1;
        end else begin
          e = expected_words.pop_front();
          if (w.cluster_index !== e.cluster_index || w.centroid_x !== e.centroid_x ||
              w.centroid_y !== e.centroid_y || w.rounds_done !== e.rounds_done ||
              w.point_label !== e.point_label || w.last !== e.last) begin
            if (errors < 10) begin
              $display("%0t: mismatch expected %p", $realtime, e);
              $display("%0t:          actual   %p", $realtime, w);
            end
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives point, centroid, run and label words plus register writes into the
// k-means core under varying idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import kmc_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_word_t            in_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_word_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  int                  pending;
  int                  errors;

  int  send_idle = 18;
  int  recv_idle = 84;
  bit  long_hold_req = 0;
  int  cur_pc;
  int  cur_mi;
  bit  label_ok [MaxPointsDef];

  always #5 clk_i = ~clk_i;

  kmeans_2d_clustering_core DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i, .out_valid_o, .out_stall_i,
    .out_word_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  kmc_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_word_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready), .pending_o(pending), .errors_o(errors)
  );

  // receiver: random stalls, or a long hold counted here
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 0;
        for (int i = 0; i < 400; i++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  initial begin
    #1_000_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send(logic [1:0] op, int slot, logic signed [31:0] x, logic signed [31:0] y);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= in_word_t'{op, 10'(slot), x, y};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // registers move only while the block is idle
  task automatic set_regs(int pc, int cc, int mi);
    drain();
    reg_write(REG_POINT_COUNT, pc);
    reg_write(REG_CLUSTER_COUNT, cc);
    reg_write(REG_MAX_ITER, mi);
    cur_pc = pc > MaxPointsDef ? MaxPointsDef : pc;
    cur_mi = mi;
  endtask

  task automatic run_clustering();
    send(OP_RUN, $urandom_range(1023), $urandom, $urandom);
    if (cur_mi > 0)
      for (int i = 0; i < cur_pc; i++) label_ok[i] = 1;
  endtask

  function automatic logic signed [31:0] rnd_coord();
    int r;
    r = $urandom_range(15);
    if (r == 0) return $urandom;
    if (r == 1) return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return ((int'($urandom_range(6)) - 3) <<< 20) + int'($urandom_range(262143)) - 131072;
  endfunction

  task automatic random_word();
    int r;
    int s;
    r = $urandom_range(99);
    s = $urandom_range(63);
    if (r < 12) run_clustering();
    else if (r < 35 && label_ok[s]) send(OP_READ_LABEL, s, $urandom, $urandom);
    else if (r < 50) send(OP_WRITE_CENT, $urandom_range(3) == 0 ? $urandom_range(1023) :
                          $urandom_range(15), rnd_coord(), rnd_coord());
    else send(OP_WRITE_POINT, s, rnd_coord(), rnd_coord());
  endtask

  initial begin
    int pc;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load: all centroids and the first 64 points
    set_regs(8, 4, 20);
    for (int c = 0; c < MaxClustersDef; c++)
      send(OP_WRITE_CENT, c, rnd_coord(), rnd_coord());
    for (int i = 0; i < 64; i++)
      send(OP_WRITE_POINT, i, rnd_coord(), rnd_coord());

    // directed: extreme coordinates, ignored centroid slots, tie on index
    send(OP_WRITE_POINT, 0, 32'sh8000_0000, 32'sh8000_0000);
    send(OP_WRITE_POINT, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send(OP_WRITE_CENT, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send(OP_WRITE_CENT, 1, 32'sh8000_0000, 32'sh8000_0000);
    send(OP_WRITE_CENT, 16, 0, 0);
    send(OP_WRITE_CENT, 1023, 32'sh7FFF_FFFF, 0);
    run_clustering();
    send(OP_READ_LABEL, 0, 0, 0);
    send(OP_READ_LABEL, 1, 0, 0);
    send(OP_WRITE_CENT, 2, 0, 0);
    send(OP_WRITE_CENT, 3, 0, 0);
    run_clustering();
    set_regs(0, 0, 65535);
    run_clustering();
    set_regs(5, 31, 0);
    run_clustering();
    set_regs(6, 1, 1);
    run_clustering();
    send(OP_READ_LABEL, 5, 0, 0);
    set_regs(16, 16, 10);
    run_clustering();

    // all loaded points, saturated cluster count
    set_regs(64, 31, 1);
    run_clustering();
    send(OP_READ_LABEL, 63, 0, 0);

    // random phases; idle mix changes every two phases
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle = 84;
        recv_idle = 18;
      end else if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      pc = ($urandom_range(4) == 0) ? $urandom_range(64) : $urandom_range(1, 20);
      set_regs(pc, $urandom_range(31), $urandom_range(3) == 0 ? $urandom_range(30) :
               $urandom_range(1, 8));
      for (int n = 0; n < 30; n++) begin
        if (ph == 1 && n == 20) begin
          // hold the output so the block backs up onto its input
          long_hold_req = 1;
          run_clustering();
          for (int j = 0; j < 6; j++) send(OP_WRITE_POINT, j, rnd_coord(), rnd_coord());
        end
        random_word();
      end
    end

    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
